// ===== src/dwqi_pkg.sv =====
// Package for the DAC write-queue interpolator: widths, kind codes, the
// command token passed from front to back, and small address/segment helpers.
// No dependencies.
package dwqi_pkg;

  localparam int QUEUE_DEPTH  = 512;
  localparam int QADDR_W      = $clog2(QUEUE_DEPTH);
  localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int LEN_W        = 12;
  localparam int SMP_W        = 16;
  localparam int MIN_SEGMENTS = 40;
  localparam int CMDQ_DEPTH   = 4;
  localparam int CMDQ_AW      = $clog2(CMDQ_DEPTH);

  // Divider geometry: dividend magnitude of diff*k, quotient up to 17 bits
  localparam int DIV_Q_W = 17;
  localparam int DIV_N_W = DIV_Q_W + LEN_W;

  localparam logic [LEN_W-1:0] FRAME_LEN_RESET = LEN_W'(735);

  // Input kind codes
  localparam logic [2:0] KIND_U8   = 3'd0;
  localparam logic [2:0] KIND_S8   = 3'd1;
  localparam logic [2:0] KIND_U16  = 3'd2;
  localparam logic [2:0] KIND_S16  = 3'd3;
  localparam logic [2:0] KIND_PULL = 3'd4;

  // One pull, fully described for the back end
  typedef struct packed {
    logic [SMP_W-1:0]   lvl;
    logic               ovf;
    logic               last;
    logic [CNT_W-1:0]   cnt;
    logic [CNT_W-1:0]   segs;
    logic [LEN_W-1:0]   flen;
    logic [LEN_W-1:0]   pos;
    logic [QADDR_W-1:0] head;
  } tok_t;

  // Circular queue address: base + offset modulo depth
  function automatic logic [QADDR_W-1:0] qaddr_add(input logic [QADDR_W-1:0] base,
                                                   input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(QUEUE_DEPTH))
      sum = sum - (CNT_W+1)'(QUEUE_DEPTH);
    return sum[QADDR_W-1:0];
  endfunction

  // Segments per frame: clamp(c/2, >= MIN_SEGMENTS, <= c-1), valid for c >= 2
  function automatic logic [CNT_W-1:0] seg_count(input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] m;
    m = c >> 1;
    if (m < CNT_W'(MIN_SEGMENTS))
      m = CNT_W'(MIN_SEGMENTS);
    if (m > c - CNT_W'(1))
      m = c - CNT_W'(1);
    return m;
  endfunction

endpackage

// ===== src/dwqi_if.sv =====
// Channel interfaces for the DAC write-queue interpolator: input items,
// result items and the frame-length write port. No dependencies.
interface dwqi_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [15:0] value;
  modport source (output valid, kind, value, input ready);
  modport sink   (input valid, kind, value, output ready);
endinterface

interface dwqi_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               frame_last;
  logic               overflowed;
  modport source (output valid, sample, frame_last, overflowed, input ready);
  modport sink   (input valid, sample, frame_last, overflowed, output ready);
endinterface

interface dwqi_cfg_if;
  logic        valid;
  logic        ready;
  logic [11:0] frame_length;
  modport source (output valid, frame_length, input ready);
  modport sink   (input valid, frame_length, output ready);
endinterface

// ===== src/dac_write_queue_interpolator_top.sv =====
// Top level of the DAC write-queue interpolator: front end, command queue,
// change-queue RAM and back end. Depends on dwqi_pkg, dwqi_if and all dwqi_* modules.
//
//  channel  | direction | payload
//  ---------+-----------+-------------------------------------------
//  in_if    | in        | kind[2:0], value[15:0]
//  out_if   | out       | sample[15:0] signed, frame_last, overflowed
//  cfg_if   | in        | frame_length[11:0]
//
// Writes are taken one per cycle unless held off as below. An interpolated pull
// runs in the back end through two queue reads, one multiply and a 17-step serial
// divide, plus the L/m divide on the first pull of a frame and one search step per
// skipped segment; an empty snapshot returns the level, a single-entry one reads it.
// Pulls queue up to four deep ahead of the back end; a write that appends to
// the queue is held off while pulls are pending. Reset (rst_n, synchronous)
// needs no clearing pass; out_if holds its result until taken.
module dac_write_queue_interpolator_top (
  input  logic      clk,
  input  logic      rst_n,
  dwqi_in_if.sink   in_if,
  dwqi_out_if.source out_if,
  dwqi_cfg_if.sink  cfg_if
);
  import dwqi_pkg::*;

  logic               tok_push, tok_full, tok_pop, tok_empty, back_busy;
  tok_t               tok_w, tok_r;
  logic               mem_we;
  logic [QADDR_W-1:0] mem_waddr, mem_raddr;
  logic [SMP_W-1:0]   mem_wdata, mem_rdata;

  dwqi_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .cfg_if    (cfg_if),
    .tok_push  (tok_push),
    .tok       (tok_w),
    .tok_full  (tok_full),
    .back_busy (back_busy || !tok_empty),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata)
  );

  dwqi_cmd_fifo u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (tok_push),
    .push_tok (tok_w),
    .full     (tok_full),
    .pop      (tok_pop),
    .pop_tok  (tok_r),
    .empty    (tok_empty)
  );

  dwqi_ram #(
    .WIDTH (SMP_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  dwqi_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_empty (tok_empty),
    .tok_in    (tok_r),
    .tok_pop   (tok_pop),
    .busy      (back_busy),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .out_if    (out_if)
  );
endmodule

// ===== src/dwqi_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module dwqi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we)
      mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

// ===== src/dwqi_cmd_fifo.sv =====
// Short command queue carrying pull tokens from the front to the back end.
// Depends on dwqi_pkg.
module dwqi_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  dwqi_pkg::tok_t push_tok,
  output logic           full,
  input  logic           pop,
  output dwqi_pkg::tok_t pop_tok,
  output logic           empty
);
  import dwqi_pkg::*;

  tok_t               slot_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wptr_r, rptr_r;
  logic [CMDQ_AW:0]   fill_r;

  assign full    = (fill_r == (CMDQ_AW+1)'(CMDQ_DEPTH));
  assign empty   = (fill_r == '0);
  assign pop_tok = slot_r[rptr_r];

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (push)
      slot_r[wptr_r] <= push_tok;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      fill_r <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + CMDQ_AW'(1);
      if (pop)  rptr_r <= rptr_r + CMDQ_AW'(1);
      case ({push, pop})
        2'b10:   fill_r <= fill_r + (CMDQ_AW+1)'(1);
        2'b01:   fill_r <= fill_r - (CMDQ_AW+1)'(1);
        default: fill_r <= fill_r;
      endcase
    end
  end
endmodule

// ===== src/dwqi_div.sv =====
// Serial restoring divider, one quotient bit per cycle, shared by the back
// end for the frame step (L/m) and the interpolation. Depends on dwqi_pkg.
module dwqi_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [dwqi_pkg::DIV_N_W-1:0] dividend,
  input  logic [dwqi_pkg::LEN_W-1:0]   divisor,
  output logic                         done,
  output logic [dwqi_pkg::DIV_Q_W-1:0] quotient,
  output logic [dwqi_pkg::LEN_W-1:0]   remainder
);
  import dwqi_pkg::*;

  localparam int STEP_W = $clog2(DIV_Q_W + 1);

  logic [LEN_W-1:0]   rem_r, rem_nxt;
  logic [DIV_Q_W-1:0] q_r, q_nxt;
  logic [LEN_W-1:0]   d_r;
  logic [STEP_W-1:0]  step_r;
  logic               busy_r, done_r;
  logic [LEN_W:0]     trial;

  // one restoring step; the caller guarantees quotient < 2^DIV_Q_W
  always_comb begin
    trial = {rem_r, q_r[DIV_Q_W-1]};
    if (trial >= {1'b0, d_r}) begin
      rem_nxt = LEN_W'(trial - {1'b0, d_r});
      q_nxt   = {q_r[DIV_Q_W-2:0], 1'b1};
    end else begin
      rem_nxt = trial[LEN_W-1:0];
      q_nxt   = {q_r[DIV_Q_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(DIV_Q_W);
      end else if (busy_r) begin
        step_r <= step_r - STEP_W'(1);
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend[DIV_N_W-1:DIV_Q_W];
      q_r   <= dividend[DIV_Q_W-1:0];
      d_r   <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r;
endmodule

// ===== src/dwqi_front.sv =====
// Front end: takes input items and frame-length writes, maps writes to the
// level, appends changes to the queue, tracks frames and issues pull tokens.
// Depends on dwqi_pkg and dwqi_if.
module dwqi_front (
  input  logic                         clk,
  input  logic                         rst_n,
  dwqi_in_if.sink                      in_if,
  dwqi_cfg_if.sink                     cfg_if,
  output logic                         tok_push,
  output dwqi_pkg::tok_t               tok,
  input  logic                         tok_full,
  input  logic                         back_busy,
  output logic                         mem_we,
  output logic [dwqi_pkg::QADDR_W-1:0] mem_waddr,
  output logic [dwqi_pkg::SMP_W-1:0]   mem_wdata
);
  import dwqi_pkg::*;

  logic [LEN_W-1:0]   flen_cfg_r;
  logic [SMP_W-1:0]   level_r, level_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [QADDR_W-1:0] head_r, head_nxt;
  logic               ovf_r, ovf_nxt;
  logic               fa_r, fa_nxt;
  logic [LEN_W-1:0]   pos_r, pos_nxt;
  logic [CNT_W-1:0]   snap_c_r, snap_c_nxt;
  logic [CNT_W-1:0]   snap_m_r, snap_m_nxt;
  logic [LEN_W-1:0]   snap_l_r, snap_l_nxt;

  logic [7:0]         v8;
  logic [SMP_W-1:0]   new_lvl;
  logic               is_byte, is_word, is_pull, changed, room;
  logic               fire;
  logic [CNT_W-1:0]   c_use, m_use, drop;
  logic [LEN_W-1:0]   l_use, p_use;
  logic               last;

  assign cfg_if.ready = 1'b1;

  // level mapping of the write kinds
  assign v8 = in_if.value[7:0];
  always_comb begin
    case (in_if.kind)
      KIND_U8:  new_lvl = {1'b0, v8, v8[7:1]};
      KIND_S8:  new_lvl = {~v8[7], v8[6:0], v8};
      KIND_U16: new_lvl = {1'b0, in_if.value[15:1]};
      default:  new_lvl = {~in_if.value[15], in_if.value[14:0]};
    endcase
  end

  assign is_byte = (in_if.kind == KIND_U8) || (in_if.kind == KIND_S8);
  assign is_word = (in_if.kind == KIND_U16) || (in_if.kind == KIND_S16);
  assign is_pull = (in_if.kind == KIND_PULL);
  assign changed = (new_lvl != level_r);
  assign room    = (count_r < CNT_W'(QUEUE_DEPTH - 1));

  // a queue write waits until the back end no longer reads the queue
  assign in_if.ready = !((is_pull && tok_full) || (is_byte && changed && room && back_busy));
  assign fire = in_if.valid && in_if.ready;

  // frame parameters, latched on the first pull of a frame
  assign c_use = fa_r ? snap_c_r : count_r;
  assign m_use = fa_r ? snap_m_r : seg_count(count_r);
  assign l_use = fa_r ? snap_l_r : ((flen_cfg_r == '0) ? LEN_W'(1) : flen_cfg_r);
  assign p_use = fa_r ? pos_r : '0;
  assign last  = ((LEN_W+1)'(p_use) + (LEN_W+1)'(1)) >= (LEN_W+1)'(l_use);

  always_comb begin
    if (c_use == '0)
      drop = '0;
    else if (c_use == CNT_W'(1))
      drop = CNT_W'(1);
    else if (c_use - CNT_W'(1) > m_use)
      drop = m_use;
    else
      drop = c_use;
  end

  assign tok = '{lvl: level_r, ovf: ovf_r, last: last, cnt: c_use, segs: m_use,
                 flen: l_use, pos: p_use, head: head_r};
  assign tok_push  = fire && is_pull;
  assign mem_we    = fire && is_byte && changed && room;
  assign mem_waddr = qaddr_add(head_r, count_r);
  assign mem_wdata = new_lvl;

  // next state
  always_comb begin
    level_nxt  = level_r;
    count_nxt  = count_r;
    head_nxt   = head_r;
    ovf_nxt    = ovf_r;
    fa_nxt     = fa_r;
    pos_nxt    = pos_r;
    snap_c_nxt = snap_c_r;
    snap_m_nxt = snap_m_r;
    snap_l_nxt = snap_l_r;
    if (fire) begin
      if (is_byte && changed) begin
        if (room) begin
          level_nxt = new_lvl;
          count_nxt = count_r + CNT_W'(1);
        end else begin
          ovf_nxt = 1'b1;
        end
      end else if (is_word) begin
        level_nxt = new_lvl;
      end else if (is_pull) begin
        if (last) begin
          head_nxt = qaddr_add(head_r, drop);
          count_nxt = count_r - drop;
          fa_nxt = 1'b0;
          pos_nxt = '0;
        end else begin
          fa_nxt = 1'b1;
          pos_nxt = p_use + LEN_W'(1);
          snap_c_nxt = c_use;
          snap_m_nxt = m_use;
          snap_l_nxt = l_use;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flen_cfg_r <= FRAME_LEN_RESET;
      level_r    <= '0;
      count_r    <= '0;
      head_r     <= '0;
      ovf_r      <= 1'b0;
      fa_r       <= 1'b0;
      pos_r      <= '0;
      snap_c_r   <= '0;
      snap_m_r   <= '0;
      snap_l_r   <= LEN_W'(1);
    end else begin
      if (cfg_if.valid)
        flen_cfg_r <= cfg_if.frame_length;
      level_r  <= level_nxt;
      count_r  <= count_nxt;
      head_r   <= head_nxt;
      ovf_r    <= ovf_nxt;
      fa_r     <= fa_nxt;
      pos_r    <= pos_nxt;
      snap_c_r <= snap_c_nxt;
      snap_m_r <= snap_m_nxt;
      snap_l_r <= snap_l_nxt;
    end
  end
endmodule

// ===== src/dwqi_back.sv =====
// Back end: computes one sample per pull token (for interpolated pulls: segment search,
// two queue reads, multiply, serial divide) and holds it in the output register.
// Depends on dwqi_pkg, dwqi_if and dwqi_div.
module dwqi_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         tok_empty,
  input  dwqi_pkg::tok_t               tok_in,
  output logic                         tok_pop,
  output logic                         busy,
  output logic [dwqi_pkg::QADDR_W-1:0] mem_raddr,
  input  logic [dwqi_pkg::SMP_W-1:0]   mem_rdata,
  dwqi_out_if.source                   out_if
);
  import dwqi_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_RD1, S_RD1D, S_LDIV, S_LWAIT, S_SEEK, S_RDA, S_RDB,
    S_IDIV, S_IWAIT, S_OUT
  } state_t;

  state_t             state_r;
  tok_t               tok_r;
  logic [CNT_W-1:0]   seg_r;
  logic [LEN_W-1:0]   start_r;
  logic [LEN_W:0]     endq_r;
  logic [CNT_W-1:0]   endr_r;
  logic [LEN_W-1:0]   lq_r;
  logic [CNT_W-1:0]   lr_r;
  logic [SMP_W-1:0]   a_r;
  logic               neg_r;
  logic [DIV_N_W-1:0] mag_r;
  logic [SMP_W-1:0]   s_r;
  logic               ov_r, ol_r, oo_r;
  logic [SMP_W-1:0]   osmp_r;

  logic               div_go, div_done;
  logic [DIV_N_W-1:0] div_n;
  logic [LEN_W-1:0]   div_d;
  logic [DIV_Q_W-1:0] div_q;
  logic [LEN_W-1:0]   div_r;

  logic               advance;
  logic [CNT_W:0]     endr_sum;
  logic signed [SMP_W:0]       diff;
  logic signed [DIV_N_W:0]     prod;
  logic signed [SMP_W+1:0]     sum;

  dwqi_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_go),
    .dividend  (div_n),
    .divisor   (div_d),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  assign tok_pop = (state_r == S_IDLE) && !tok_empty;
  assign busy    = (state_r != S_IDLE);

  // divider operands: frame step L/m, or |diff*k| / segment length
  assign div_go = (state_r == S_LDIV) || (state_r == S_IDIV);
  assign div_n  = (state_r == S_LDIV) ? DIV_N_W'(tok_r.flen) : mag_r;
  assign div_d  = (state_r == S_LDIV) ? LEN_W'(tok_r.segs)
                                      : LEN_W'(endq_r - (LEN_W+1)'(start_r));

  // segment search: step while the segment ends at or before the position and a later segment exists
  assign advance = (endq_r <= (LEN_W+1)'(tok_r.pos)) &&
                   ((seg_r + CNT_W'(1)) < tok_r.segs);
  assign endr_sum = (CNT_W+1)'(endr_r) + (CNT_W+1)'(lr_r);

  // queue read address
  always_comb begin
    case (state_r)
      S_RD1:   mem_raddr = tok_r.head;
      S_RDA:   mem_raddr = qaddr_add(tok_r.head, seg_r + CNT_W'(1));
      default: mem_raddr = qaddr_add(tok_r.head, seg_r);
    endcase
  end

  // interpolation product and final sum
  assign diff = $signed({mem_rdata[SMP_W-1], mem_rdata}) - $signed({a_r[SMP_W-1], a_r});
  assign prod = diff * $signed({1'b0, tok_r.pos - start_r});
  assign sum  = neg_r ? $signed({{2{a_r[SMP_W-1]}}, a_r}) - $signed({1'b0, div_q})
                      : $signed({{2{a_r[SMP_W-1]}}, a_r}) + $signed({1'b0, div_q});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      // output register empties on a transfer unless refilled below
      if (out_if.ready && state_r != S_OUT)
        ov_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (!tok_empty) begin
            tok_r <= tok_in;
            if (tok_in.cnt == '0) begin
              s_r     <= tok_in.lvl;
              state_r <= S_OUT;
            end else if (tok_in.cnt == CNT_W'(1)) begin
              state_r <= S_RD1;
            end else if (tok_in.pos == '0) begin
              seg_r   <= '0;
              start_r <= '0;
              state_r <= S_LDIV;
            end else begin
              state_r <= S_SEEK;
            end
          end
        end
        S_RD1:  state_r <= S_RD1D;
        S_RD1D: begin
          s_r     <= mem_rdata;
          state_r <= S_OUT;
        end
        S_LDIV: state_r <= S_LWAIT;
        S_LWAIT: begin
          if (div_done) begin
            lq_r    <= div_q[LEN_W-1:0];
            lr_r    <= CNT_W'(div_r);
            endq_r  <= (LEN_W+1)'(div_q[LEN_W-1:0]);
            endr_r  <= CNT_W'(div_r);
            state_r <= S_SEEK;
          end
        end
        S_SEEK: begin
          if (advance) begin
            start_r <= endq_r[LEN_W-1:0];
            seg_r   <= seg_r + CNT_W'(1);
            if (endr_sum >= (CNT_W+1)'(tok_r.segs)) begin
              endq_r <= endq_r + (LEN_W+1)'(lq_r) + (LEN_W+1)'(1);
              endr_r <= CNT_W'(endr_sum - (CNT_W+1)'(tok_r.segs));
            end else begin
              endq_r <= endq_r + (LEN_W+1)'(lq_r);
              endr_r <= endr_sum[CNT_W-1:0];
            end
          end else begin
            state_r <= S_RDA;
          end
        end
        S_RDA: begin
          a_r     <= mem_rdata;
          state_r <= S_RDB;
        end
        S_RDB: begin
          neg_r   <= prod[DIV_N_W];
          mag_r   <= prod[DIV_N_W] ? DIV_N_W'(-prod) : prod[DIV_N_W-1:0];
          state_r <= S_IDIV;
        end
        S_IDIV: state_r <= S_IWAIT;
        S_IWAIT: begin
          if (div_done) begin
            s_r     <= sum[SMP_W-1:0];
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!ov_r || out_if.ready) begin
            ov_r    <= 1'b1;
            osmp_r  <= s_r;
            ol_r    <= tok_r.last;
            oo_r    <= tok_r.ovf;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_if.valid      = ov_r;
  assign out_if.sample     = osmp_r;
  assign out_if.frame_last = ol_r;
  assign out_if.overflowed = oo_r;
endmodule
